// File: rtl/v3u_pkg.sv
// ----------------------------------------------------------------------------
// v3u_pkg
// Shared constants, operation codes, the pipeline item type and the clamp
// helper for the 3D vector unit.
// ----------------------------------------------------------------------------
package v3u_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQRT_CELLS = 32;               // one root bit per cell
    localparam int DIV_CELLS  = FRAC_BITS + 2;    // one quotient bit per cell
    localparam int NUM_W      = 32 + FRAC_BITS;   // rounded dividend width

    localparam logic [2:0] K_ADD   = 3'd0;
    localparam logic [2:0] K_SUB   = 3'd1;
    localparam logic [2:0] K_DOT   = 3'd2;
    localparam logic [2:0] K_CROSS = 3'd3;
    localparam logic [2:0] K_MAG   = 3'd4;
    localparam logic [2:0] K_NORM  = 3'd5;

    typedef struct packed {
        logic                              valid;
        logic [2:0]                        kind;
        logic signed [31:0]                res_x;
        logic signed [31:0]                res_y;
        logic signed [31:0]                res_z;
        logic                              sat;
        logic                              zero;
        logic [2:0]                        a_neg;
        logic [2:0][31:0]                  mag;
        logic [63:0]                       rad;
        logic [33:0]                       srem;
        logic [31:0]                       root;
        logic [31:0]                       m;
        logic [2:0][31:0]                  drem;
        logic [2:0][DIV_CELLS-1:0]         num;
        logic [2:0][DIV_CELLS-1:0]         quo;
    } t_item;

    // {saturated, value}
    function automatic logic [32:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, v[31:0]};
        end
    endfunction

endpackage

// File: rtl/v3u_in_if.sv
// ----------------------------------------------------------------------------
// v3u_in_if
// Request channel: operation kind and the two operand vectors.
// ----------------------------------------------------------------------------
interface v3u_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;

    modport source (output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
    modport sink   (input valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

// File: rtl/v3u_out_if.sv
// ----------------------------------------------------------------------------
// v3u_out_if
// Result channel: vector or scalar result and status flags.
// ----------------------------------------------------------------------------
interface v3u_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               saturated;
    logic               zero_length;

    modport source (output valid, r_x, r_y, r_z, saturated, zero_length, input ready);
    modport sink   (input valid, r_x, r_y, r_z, saturated, zero_length, output ready);
endinterface

// File: rtl/v3u_front.sv
// ----------------------------------------------------------------------------
// v3u_front
// Two front stages: shared multipliers and add/sub, then exact sums with
// rounding and clamping. Emits the item that enters the root chain.
// ----------------------------------------------------------------------------
module v3u_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    output v3u_pkg::t_item     o_item
);

    localparam logic signed [65:0] HALF = 66'sd1 <<< (v3u_pkg::FRAC_BITS - 1);

    logic signed [31:0] ma [6];
    logic signed [31:0] mb [6];
    logic signed [63:0] n_p [6];
    logic signed [31:0] n_add [3];
    logic               n_add_sat;
    logic [2:0]         n_neg;
    logic [2:0][31:0]   n_mag;
    logic signed [32:0] s33 [3];
    logic [32:0]        cl [3];

    logic               r1_v;
    logic [2:0]         r1_kind;
    logic signed [63:0] r1_p [6];
    logic signed [31:0] r1_add [3];
    logic               r1_add_sat;
    logic [2:0]         r1_neg;
    logic [2:0][31:0]   r1_mag;

    v3u_pkg::t_item     r_q;
    v3u_pkg::t_item     n_q;

    logic signed [65:0] sum3, dot_r, cx_r, cy_r, cz_r;
    logic [32:0]        c0, c1, c2;

    // stage 1: operand select, multiply, add/sub
    always_comb begin
        ma[0] = i_a_y; mb[0] = i_b_z;
        ma[1] = i_a_z; mb[1] = i_b_y;
        ma[2] = i_a_z; mb[2] = i_b_x;
        ma[3] = i_a_x; mb[3] = i_b_z;
        ma[4] = i_a_x; mb[4] = i_b_y;
        ma[5] = i_a_y; mb[5] = i_b_x;
        if (i_kind == v3u_pkg::K_DOT) begin
            ma[0] = i_a_x; mb[0] = i_b_x;
            ma[1] = i_a_y; mb[1] = i_b_y;
            ma[2] = i_a_z; mb[2] = i_b_z;
        end else if (i_kind == v3u_pkg::K_MAG || i_kind == v3u_pkg::K_NORM) begin
            ma[0] = i_a_x; mb[0] = i_a_x;
            ma[1] = i_a_y; mb[1] = i_a_y;
            ma[2] = i_a_z; mb[2] = i_a_z;
        end
        for (int i = 0; i < 6; i++) begin
            n_p[i] = 64'(ma[i]) * 64'(mb[i]);
        end
        if (i_kind == v3u_pkg::K_SUB) begin
            s33[0] = 33'(i_a_x) - 33'(i_b_x);
            s33[1] = 33'(i_a_y) - 33'(i_b_y);
            s33[2] = 33'(i_a_z) - 33'(i_b_z);
        end else begin
            s33[0] = 33'(i_a_x) + 33'(i_b_x);
            s33[1] = 33'(i_a_y) + 33'(i_b_y);
            s33[2] = 33'(i_a_z) + 33'(i_b_z);
        end
        n_add_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            cl[i]     = v3u_pkg::clamp32(66'(s33[i]));
            n_add[i]  = cl[i][31:0];
            n_add_sat = n_add_sat | cl[i][32];
        end
        n_neg    = {i_a_z[31], i_a_y[31], i_a_x[31]};
        n_mag[0] = i_a_x[31] ? 32'(-i_a_x) : i_a_x;
        n_mag[1] = i_a_y[31] ? 32'(-i_a_y) : i_a_y;
        n_mag[2] = i_a_z[31] ? 32'(-i_a_z) : i_a_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind    <= i_kind;
            r1_p       <= n_p;
            r1_add     <= n_add;
            r1_add_sat <= n_add_sat;
            r1_neg     <= n_neg;
            r1_mag     <= n_mag;
        end
    end

    // stage 2: exact sums, round half up, clamp
    always_comb begin
        sum3  = 66'(r1_p[0]) + 66'(r1_p[1]) + 66'(r1_p[2]);
        dot_r = (sum3 + HALF) >>> v3u_pkg::FRAC_BITS;
        cx_r  = (66'(r1_p[0]) - 66'(r1_p[1]) + HALF) >>> v3u_pkg::FRAC_BITS;
        cy_r  = (66'(r1_p[2]) - 66'(r1_p[3]) + HALF) >>> v3u_pkg::FRAC_BITS;
        cz_r  = (66'(r1_p[4]) - 66'(r1_p[5]) + HALF) >>> v3u_pkg::FRAC_BITS;
        c0    = v3u_pkg::clamp32(cx_r);
        c1    = v3u_pkg::clamp32(cy_r);
        c2    = v3u_pkg::clamp32(cz_r);

        n_q       = '0;
        n_q.valid = r1_v;
        n_q.kind  = r1_kind;
        n_q.a_neg = r1_neg;
        n_q.mag   = r1_mag;
        case (r1_kind)
            v3u_pkg::K_ADD, v3u_pkg::K_SUB: begin
                n_q.res_x = r1_add[0];
                n_q.res_y = r1_add[1];
                n_q.res_z = r1_add[2];
                n_q.sat   = r1_add_sat;
            end
            v3u_pkg::K_DOT: begin
                {n_q.sat, n_q.res_x} = v3u_pkg::clamp32(dot_r);
            end
            v3u_pkg::K_CROSS: begin
                n_q.res_x = c0[31:0];
                n_q.res_y = c1[31:0];
                n_q.res_z = c2[31:0];
                n_q.sat   = c0[32] | c1[32] | c2[32];
            end
            v3u_pkg::K_MAG, v3u_pkg::K_NORM: begin
                n_q.rad  = sum3[63:0];
                n_q.zero = (r1_kind == v3u_pkg::K_NORM) && (sum3 == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_item = r_q;

endmodule

// File: rtl/v3u_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v3u_sqrt_cell
// One cell of the square-root chain: brings in two radicand bits and
// decides one root bit.
// ----------------------------------------------------------------------------
module v3u_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  v3u_pkg::t_item i_item,
    output v3u_pkg::t_item o_item
);

    v3u_pkg::t_item r_q;
    v3u_pkg::t_item n_q;
    logic [35:0]    cand;
    logic [35:0]    trial;
    logic           fit;

    always_comb begin
        cand   = {i_item.srem, i_item.rad[63:62]};
        trial  = {2'b00, i_item.root, 2'b01};
        fit    = (cand >= trial);
        n_q      = i_item;
        n_q.srem = fit ? 34'(cand - trial) : cand[33:0];
        n_q.root = {i_item.root[30:0], fit};
        n_q.rad  = {i_item.rad[61:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_item = r_q;

endmodule

// File: rtl/v3u_div_cell.sv
// ----------------------------------------------------------------------------
// v3u_div_cell
// One cell of the normalize divider chain: one restoring quotient bit for
// each of the three lanes.
// ----------------------------------------------------------------------------
module v3u_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  v3u_pkg::t_item i_item,
    output v3u_pkg::t_item o_item
);

    v3u_pkg::t_item r_q;
    v3u_pkg::t_item n_q;
    logic [32:0]    cand [3];
    logic           fit  [3];

    always_comb begin
        n_q = i_item;
        for (int i = 0; i < 3; i++) begin
            cand[i]     = {i_item.drem[i], i_item.num[i][v3u_pkg::DIV_CELLS-1]};
            fit[i]      = (cand[i] >= {1'b0, i_item.m});
            n_q.drem[i] = fit[i] ? 32'(cand[i] - {1'b0, i_item.m}) : cand[i][31:0];
            n_q.num[i]  = i_item.num[i] << 1;
            n_q.quo[i]  = {i_item.quo[i][v3u_pkg::DIV_CELLS-2:0], fit[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_item = r_q;

endmodule

// File: rtl/vec3_vector_unit_top.sv
// ----------------------------------------------------------------------------
// vec3_vector_unit_top
// Pipelined 3D vector unit on signed Q16.16 vectors.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation (add, sub, dot, cross, magnitude, normalize
//   of A) with vectors A and B; o_rsp returns one result per request, in
//   order. Scalars come back in r_x with r_y, r_z zero. Clamped values set
//   saturated; normalize of the zero vector sets zero_length.
// Throughput: one transfer per cycle on both channels while o_rsp.ready is high.
// Path: two front stages, one cell per root bit, a rounding stage, one cell
//   per quotient bit, a finishing stage and the output register. Every kind
//   takes the same path.
// Stall: when o_rsp.ready is low the pipeline keeps advancing until a valid
//   item is caught in the skid register, then holds; i_req.ready drops only
//   while the skid register is occupied.
// Reset: clears all valid bits; nothing else is held between items.
// ----------------------------------------------------------------------------
module vec3_vector_unit_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    v3u_in_if.sink    i_req,
    v3u_out_if.source o_rsp
);

    localparam int NW = v3u_pkg::NUM_W;
    localparam int DC = v3u_pkg::DIV_CELLS;
    localparam int FB = v3u_pkg::FRAC_BITS;

    logic           en;
    v3u_pkg::t_item w_sq [v3u_pkg::SQRT_CELLS+1];
    v3u_pkg::t_item w_dv [DC+1];

    v3u_pkg::t_item r_set, n_set;
    v3u_pkg::t_item r_fin, n_fin;
    v3u_pkg::t_item r_out, r_skid;
    logic           r_out_v, r_skid_v;
    logic           take;

    logic           rnd;
    logic [32:0]    m33;
    logic [NW-1:0]  np [3];

    assign en          = !r_skid_v;
    assign i_req.ready = en;

    v3u_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_kind  (i_req.kind),
        .i_a_x   (i_req.a_x),
        .i_a_y   (i_req.a_y),
        .i_a_z   (i_req.a_z),
        .i_b_x   (i_req.b_x),
        .i_b_y   (i_req.b_y),
        .i_b_z   (i_req.b_z),
        .o_item  (w_sq[0])
    );

    for (genvar g = 0; g < v3u_pkg::SQRT_CELLS; g++) begin : g_sqrt
        v3u_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (w_sq[g]),
            .o_item  (w_sq[g+1])
        );
    end

    // round the root, finish magnitude, set up the normalize dividends
    always_comb begin
        n_set = w_sq[v3u_pkg::SQRT_CELLS];
        rnd   = ({2'b00, n_set.root} < n_set.srem);
        m33   = {1'b0, n_set.root} + {32'd0, rnd};
        n_set.m = m33[31:0];
        if (n_set.kind == v3u_pkg::K_MAG) begin
            {n_set.sat, n_set.res_x} = v3u_pkg::clamp32($signed({33'd0, m33}));
        end
        for (int i = 0; i < 3; i++) begin
            np[i]          = {n_set.mag[i], {FB{1'b0}}} + NW'(m33[31:1]);
            n_set.drem[i]  = 32'(np[i][NW-1:DC]);
            n_set.num[i]   = np[i][DC-1:0];
            n_set.quo[i]   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set.valid <= 1'b0;
        end else if (en) begin
            r_set <= n_set;
        end
    end

    assign w_dv[0] = r_set;

    for (genvar g = 0; g < DC; g++) begin : g_div
        v3u_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (w_dv[g]),
            .o_item  (w_dv[g+1])
        );
    end

    // apply signs to the normalize quotients
    always_comb begin
        n_fin = w_dv[DC];
        if (n_fin.kind == v3u_pkg::K_NORM && !n_fin.zero) begin
            n_fin.res_x = n_fin.a_neg[0] ? -32'(n_fin.quo[0]) : 32'(n_fin.quo[0]);
            n_fin.res_y = n_fin.a_neg[1] ? -32'(n_fin.quo[1]) : 32'(n_fin.quo[1]);
            n_fin.res_z = n_fin.a_neg[2] ? -32'(n_fin.quo[2]) : 32'(n_fin.quo[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin.valid <= 1'b0;
        end else if (en) begin
            r_fin <= n_fin;
        end
    end

    // output register with skid
    assign take = !r_out_v || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            r_out_v  <= r_skid_v ? 1'b1 : r_fin.valid;
            r_skid_v <= 1'b0;
        end else if (en && r_fin.valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_v ? r_skid : r_fin;
        end else if (en && r_fin.valid) begin
            r_skid <= r_fin;
        end
    end

    assign o_rsp.valid       = r_out_v;
    assign o_rsp.r_x         = r_out.res_x;
    assign o_rsp.r_y         = r_out.res_y;
    assign o_rsp.r_z         = r_out.res_z;
    assign o_rsp.saturated   = r_out.sat;
    assign o_rsp.zero_length = r_out.zero;

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3D vector unit: directed table, then random
// operations with random idling on both channels, results checked in order.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic               known;
        logic signed [31:0] ex, ey, ez;
        logic               esat, ezero;
    } t_row;

    typedef struct packed {
        logic signed [31:0] x, y, z;
        logic               sat, zero;
    } t_vres;

    localparam int LATENCY = v3u_pkg::SQRT_CELLS + v3u_pkg::DIV_CELLS + 5;
    localparam int N_RANDOM = 1200;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    v3u_in_if  req_if ();
    v3u_out_if rsp_if ();

    vec3_vector_unit_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    t_vres  expected_q[$];
    t_vres  typed_q[$];
    logic   typed_known_q[$];
    int     errors;
    longint cycles;
    bit     quiet;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Clamp to the signed 32-bit range, sticking the saturation flag.
    function automatic logic signed [31:0] sat32(input logic signed [127:0] v,
                                                 inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Exact sum, then round to nearest with ties toward plus infinity.
    function automatic logic signed [127:0] fix_round(input logic signed [127:0] s);
        return (s + (128'sd1 <<< (v3u_pkg::FRAC_BITS - 1))) >>> v3u_pkg::FRAC_BITS;
    endfunction

    function automatic logic [63:0] root_nearest(input logic [127:0] s);
        logic [127:0] r;
        logic [127:0] b;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            b = r | (128'd1 << i);
            if (b * b <= s) r = b;
        end
        // round up when s - r^2 exceeds r (r^2 + r + 1/4 boundary)
        if (s - r * r > r) r = r + 1;
        return r[63:0];
    endfunction

    function automatic logic signed [127:0] scaled_div(input logic signed [127:0] a,
                                                       input logic [127:0] m);
        logic [127:0] n;
        logic [127:0] q;
        n = (a < 0 ? -a : a) << v3u_pkg::FRAC_BITS;
        q = (n + m / 2) / m;
        return a < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_vres vec_predict(input t_row t);
        t_vres r;
        logic signed [127:0] ax, ay, az, bx, by, bz, px, py, pz;
        logic [127:0] s;
        logic [63:0] m;
        logic sat;
        ax = t.ax; ay = t.ay; az = t.az;
        bx = t.bx; by = t.by; bz = t.bz;
        px = 0; py = 0; pz = 0;
        sat = 1'b0;
        r.zero = 1'b0;
        case (t.kind)
            v3u_pkg::K_ADD: begin
                px = ax + bx; py = ay + by; pz = az + bz;
            end
            v3u_pkg::K_SUB: begin
                px = ax - bx; py = ay - by; pz = az - bz;
            end
            v3u_pkg::K_DOT: px = fix_round(ax * bx + ay * by + az * bz);
            v3u_pkg::K_CROSS: begin
                px = fix_round(ay * bz - az * by);
                py = fix_round(az * bx - ax * bz);
                pz = fix_round(ax * by - ay * bx);
            end
            v3u_pkg::K_MAG, v3u_pkg::K_NORM: begin
                s = ax * ax + ay * ay + az * az;
                m = root_nearest(s);
                if (t.kind == v3u_pkg::K_MAG) begin
                    px = m;
                end else if (s == 0) begin
                    r.zero = 1'b1;
                end else begin
                    px = scaled_div(ax, m);
                    py = scaled_div(ay, m);
                    pz = scaled_div(az, m);
                end
            end
            default: ;
        endcase
        r.x = sat32(px, sat);
        r.y = sat32(py, sat);
        r.z = sat32(pz, sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Push one operation across the request channel and queue its result.
    task automatic send_op(input t_row t);
        t_vres p;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind  <= t.kind;
        req_if.a_x <= t.ax; req_if.a_y <= t.ay; req_if.a_z <= t.az;
        req_if.b_x <= t.bx; req_if.b_y <= t.by; req_if.b_z <= t.bz;
        p = vec_predict(t);
        do @(posedge i_clk); while (!req_if.ready);
        expected_q.push_back(p);
        typed_known_q.push_back(t.known);
        if (t.known) typed_q.push_back('{t.ex, t.ey, t.ez, t.esat, t.ezero});
        @(negedge i_clk);
    endtask

    // Response sink: random stall bursts, then steady ready near the end.
    initial begin
        rsp_if.ready = 1'b0;
        @(negedge i_clk);
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_vres e;
        t_vres k;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                         rsp_if.r_x, rsp_if.r_y, rsp_if.r_z);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (typed_known_q.pop_front()) begin
                    k = typed_q.pop_front();
                    if (k != e) begin
                        $display("%0t: row %h %h %h %b %b pred %h %h %h %b %b",
                                 $time, k.x, k.y, k.z, k.sat, k.zero,
                                 e.x, e.y, e.z, e.sat, e.zero);
                        errors++;
                    end
                end
                if (rsp_if.r_x !== e.x || rsp_if.r_y !== e.y || rsp_if.r_z !== e.z
                    || rsp_if.saturated !== e.sat || rsp_if.zero_length !== e.zero) begin
                    $display("%0t: exp %h %h %h %b %b got %h %h %h %b %b",
                             $time, e.x, e.y, e.z, e.sat, e.zero, rsp_if.r_x, rsp_if.r_y,
                             rsp_if.r_z, rsp_if.saturated, rsp_if.zero_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    t_row directed[] = '{
        '{v3u_pkg::K_ADD, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
        '{v3u_pkg::K_ADD, MAXV, MINV, 1, 1, -1, 2, 1, MAXV, MINV, 3, 1, 0},
        '{v3u_pkg::K_SUB, MINV, MAXV, 0, 1, -1, MINV, 1, MINV, MAXV, MAXV, 1, 0},
        '{v3u_pkg::K_SUB, ONE, 2 * ONE, 3, ONE, ONE, 3, 1, 0, ONE, 0, 0, 0},
        '{v3u_pkg::K_DOT, ONE, ONE, ONE, ONE, 2 * ONE, 3 * ONE, 1, 6 * ONE, 0, 0, 0, 0},
        '{v3u_pkg::K_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 1, MAXV, 0, 0, 1, 0},
        '{v3u_pkg::K_DOT, MAXV, 0, 0, MINV, 0, 0, 1, MINV, 0, 0, 1, 0},
        '{v3u_pkg::K_DOT, 1, 0, 0, 32'sh8000, 0, 0, 1, 1, 0, 0, 0, 0},
        '{v3u_pkg::K_DOT, -1, 0, 0, 32'sh8000, 0, 0, 1, 0, 0, 0, 0, 0},
        '{v3u_pkg::K_CROSS, ONE, 0, 0, 0, ONE, 0, 1, 0, 0, ONE, 0, 0},
        '{v3u_pkg::K_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, 0, 0, 0, 0, 0},
        '{v3u_pkg::K_MAG, 3 * ONE, 4 * ONE, 0, 5, 5, 5, 1, 5 * ONE, 0, 0, 0, 0},
        '{v3u_pkg::K_MAG, MINV, MINV, MINV, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{v3u_pkg::K_MAG, 0, 0, 0, MAXV, MAXV, MAXV, 1, 0, 0, 0, 0, 0},
        '{v3u_pkg::K_NORM, 0, 0, 0, ONE, ONE, ONE, 1, 0, 0, 0, 0, 1},
        '{v3u_pkg::K_NORM, 5 * ONE, 0, 0, 0, 0, 0, 1, ONE, 0, 0, 0, 0},
        '{v3u_pkg::K_NORM, 0, -7, 0, 0, 0, 0, 1, 0, -ONE, 0, 0, 0},
        '{v3u_pkg::K_NORM, MINV, MAXV, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{v3u_pkg::K_NORM, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{3'd6, 1, 2, 3, 4, 5, 6, 1, 0, 0, 0, 0, 0},
        '{3'd7, MINV, MINV, MINV, MAXV, MAXV, MAXV, 1, 0, 0, 0, 0, 0}
    };

    initial begin
        t_row t;
        int waited;
        errors = 0;
        cycles = 0;
        quiet  = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.kind = '0;
        req_if.a_x = '0; req_if.a_y = '0; req_if.a_z = '0;
        req_if.b_x = '0; req_if.b_y = '0; req_if.b_z = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[i]) send_op(directed[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 150) quiet = 1'b1;
            t.kind = $urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            t.ax = rand_comp(); t.ay = rand_comp(); t.az = rand_comp();
            t.bx = rand_comp(); t.by = rand_comp(); t.bz = rand_comp();
            t.known = 1'b0;
            send_op(t);
        end
        req_if.valid <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
